FILE: hw/rtl/compacting_list_store_core_defines.svh
// Assertion macros for the checker file of the list store.
`ifndef COMPACTING_LIST_STORE_CORE_DEFINES_SVH
`define COMPACTING_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CLSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CLSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/clsc_pkg.sv
package clsc_pkg;

   // Fixed field widths
   localparam int unsigned WORD_W = 64;
   localparam int unsigned POS_W  = 6;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned FILL_W = 7;

   // Request kinds
   typedef logic [KIND_W-1:0] clsc_kind_type;
   localparam clsc_kind_type KIND_APPEND = 2'd0;
   localparam clsc_kind_type KIND_DELETE = 2'd1;
   localparam clsc_kind_type KIND_GET    = 2'd2;

   // Response status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } clsc_status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_GET_WAIT,
      S_SHIFT,
      S_FINISH
   } clsc_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic            capture;
      logic            do_append;
      logic            set_status;
      clsc_status_type status;
      logic            get_read;
      logic            get_load;
      logic            del_start;
      logic            shift_step;
      logic            del_finish;
      logic            rsp_load;
   } clsc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      clsc_kind_type kind;
      logic          full;
      logic          in_range;
      logic          shift_more;
      logic          shift_pend;
      logic          rsp_busy;
   } clsc_sts_type;

endpackage

FILE: hw/rtl/clsc_ctrl.sv
module clsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  clsc_pkg::clsc_sts_type sts,
   output clsc_pkg::clsc_cmd_type cmd
);
   import clsc_pkg::*;

   clsc_state_type state_ff;
   clsc_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_DONE;
      req_stall  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.kind)
               KIND_APPEND: begin
                  cmd.set_status = 1'b1;
                  if (sts.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.do_append = 1'b1;
                  end
                  state_in = S_FINISH;
               end
               KIND_DELETE: begin
                  if (sts.in_range) begin
                     cmd.del_start = 1'b1;
                     state_in      = S_SHIFT;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                     state_in       = S_FINISH;
                  end
               end
               KIND_GET: begin
                  if (sts.in_range) begin
                     cmd.get_read = 1'b1;
                     state_in     = S_GET_WAIT;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                     state_in       = S_FINISH;
                  end
               end
               default: begin
                  // unused kind code
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_RANGE;
                  state_in       = S_FINISH;
               end
            endcase
         end
         S_GET_WAIT: begin
            cmd.get_load = 1'b1;
            state_in     = S_FINISH;
         end
         S_SHIFT: begin
            // move entries down until the read pointer passes the end and the last write drains
            if (!sts.shift_more && !sts.shift_pend) begin
               cmd.del_finish = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/clsc_dpath.sv
module clsc_dpath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [clsc_pkg::KIND_W-1:0]     req_kind,
   input  logic [clsc_pkg::POS_W-1:0]      req_position,
   input  logic [clsc_pkg::WORD_W-1:0]     req_word_in,
   input  clsc_pkg::clsc_cmd_type          cmd,
   output clsc_pkg::clsc_sts_type          sts,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [clsc_pkg::WORD_W-1:0]     rsp_word_out,
   output logic [clsc_pkg::FILL_W-1:0]     rsp_fill_count
);
   import clsc_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

   // Entry memory
   logic [WORD_W-1:0] mem [CAPACITY];

   // Request capture
   clsc_kind_type      kind_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [WORD_W-1:0]  word_ff;

   // List state and shift pipeline
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic               pend_ff;
   logic [WORD_W-1:0]  rd_ff;

   // Result held until the output slot frees
   clsc_status_type    res_status_ff;
   logic [WORD_W-1:0]  res_word_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic [FILL_W-1:0]  rsp_fill_ff;

   logic [CNT_W+POS_W-1:0]  pos_ext;
   logic [CNT_W+POS_W-1:0]  cnt_ext;
   logic [CNT_W+FILL_W-1:0] fill_wide;
   logic [ADDR_W-1:0]       pos_addr;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [WORD_W-1:0]       mem_wdata;
   logic                    mem_re;
   logic [ADDR_W-1:0]       mem_raddr;
   logic                    shift_more;

   // Comparisons on a common width
   assign pos_ext    = {{CNT_W{1'b0}}, pos_ff};
   assign cnt_ext    = {{POS_W{1'b0}}, count_ff};
   assign pos_addr   = pos_ext[ADDR_W-1:0];
   assign shift_more = (ptr_ff < count_ff);
   assign fill_wide  = {{FILL_W{1'b0}}, count_ff};

   assign sts.kind       = kind_ff;
   assign sts.full       = (count_ff == CNT_W'(CAPACITY));
   assign sts.in_range   = (pos_ext < cnt_ext);
   assign sts.shift_more = shift_more;
   assign sts.shift_pend = pend_ff;
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   // Memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = word_ff;
      mem_re    = 1'b0;
      mem_raddr = pos_addr;
      if (cmd.do_append) begin
         mem_we = 1'b1;
      end
      if (cmd.shift_step && pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = rd_ff;
      end
      if (cmd.get_read) begin
         mem_re = 1'b1;
      end
      if (cmd.shift_step && shift_more) begin
         mem_re    = 1'b1;
         mem_raddr = ptr_ff[ADDR_W-1:0];
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         word_ff <= req_word_in;
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_append) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.del_finish) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Shift pointer: read at ptr, write the previous read one place lower
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.del_start) begin
         pend_ff <= 1'b0;
      end else if (cmd.shift_step) begin
         pend_ff <= shift_more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.del_start) begin
         ptr_ff <= CNT_W'(pos_addr) + CNT_W'(1);
      end else if (cmd.shift_step && shift_more) begin
         ptr_ff     <= ptr_ff + CNT_W'(1);
         wr_addr_ff <= ptr_ff[ADDR_W-1:0] - ADDR_W'(1);
      end
   end

   // Result fields
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
         res_word_ff   <= '0;
      end else if (cmd.get_load) begin
         res_status_ff <= ST_DONE;
         res_word_ff   <= rd_ff;
      end else if (cmd.del_finish) begin
         res_status_ff <= ST_DONE;
         res_word_ff   <= '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_word_ff   <= res_word_ff;
         rsp_fill_ff   <= fill_wide[FILL_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_word_out   = rsp_word_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

FILE: hw/rtl/compacting_list_store_core.sv
// Ordered list of up to CAPACITY 64-bit words held in a one-write, one-read memory with
// registered read data. Each request transfer is append (kind 0), delete at position
// (kind 1) or get at position (kind 2); each gets exactly one response transfer with a
// status (done, full, out of range), the word read by a get (zero otherwise) and the entry
// count after the request, truncated to 7 bits. One request is worked on at a time;
// the next is taken while a response still waits in the output register. Append and
// rejected requests go through the execute and finish states; a get also waits for the
// registered read, and a delete shifts one entry per cycle through the single write port.
// Position is 6 bits wide, so with CAPACITY above 64 only the first 64 entries are
// addressable for get and delete.
module compacting_list_store_core #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [clsc_pkg::KIND_W-1:0] req_kind,
   input  logic [clsc_pkg::POS_W-1:0]  req_position,
   input  logic [clsc_pkg::WORD_W-1:0] req_word_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [clsc_pkg::WORD_W-1:0] rsp_word_out,
   output logic [clsc_pkg::FILL_W-1:0] rsp_fill_count
);
   import clsc_pkg::*;

   clsc_cmd_type cmd;
   clsc_sts_type sts;

   // Sequencer
   clsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, count and output register
   clsc_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_word_in    (req_word_in),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_word_out   (rsp_word_out),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

FILE: hw/rtl/clsc_checker.sv
`include "compacting_list_store_core_defines.svh"

module clsc_checker #(
   parameter int unsigned CAPACITY = 64
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [1:0]                  rsp_status,
   input logic [clsc_pkg::WORD_W-1:0] rsp_word_out,
   input logic [clsc_pkg::FILL_W-1:0] rsp_fill_count
);
   import clsc_pkg::*;

   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CAPACITY);

   logic       req_xfer;
   logic       rsp_xfer;
   logic       rsp_failed;
   logic       rsp_full;
   logic       rsp_wait;
   logic [1:0] open_ff;

   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign rsp_failed = rsp_valid && (rsp_status != ST_DONE);
   assign rsp_full   = rsp_valid && (rsp_status == ST_FULL);
   assign rsp_wait   = rsp_valid && rsp_stall;

   // Requests taken whose response has not been transferred yet
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         open_ff <= open_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         open_ff <= open_ff - 2'd1;
      end
   end

   `CLSC_ASSERT_NOW(a_no_extra_rsp, rsp_valid, open_ff != 2'd0, "response without a request")
   `CLSC_ASSERT_NOW(a_fail_zero, rsp_failed, rsp_word_out == '0, "failed request gave a word")
   `CLSC_ASSERT_NOW(a_full_count, rsp_full, rsp_fill_count == FULL_FILL, "full below capacity")
   `CLSC_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_word_out), "stall not held")

endmodule

bind compacting_list_store_core clsc_checker #(.CAPACITY(CAPACITY)) u_clsc_checker (.*);

FILE: tb/list_store_checker.sv
module list_store_checker #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [clsc_pkg::KIND_W-1:0]   req_kind,
   input  logic [clsc_pkg::POS_W-1:0]    req_position,
   input  logic [clsc_pkg::WORD_W-1:0]   req_word_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [clsc_pkg::WORD_W-1:0]   rsp_word_out,
   input  logic [clsc_pkg::FILL_W-1:0]   rsp_fill_count,
   output int                            mismatch_count,
   output int                            pending_replies,
   output int                            predicted_fill
);
   import clsc_pkg::*;

   typedef struct packed {
      clsc_status_type    status;
      logic [WORD_W-1:0]  word;
      logic [FILL_W-1:0]  fill;
   } list_reply_type;

   // Shadow copy of the list contents and its entry count
   logic [WORD_W-1:0] shadow_words [CAPACITY];
   int unsigned       shadow_count;
   list_reply_type    expected_replies [$];

   // Apply one accepted request to the shadow list, return the reply it must produce
   function automatic list_reply_type apply_request(input clsc_kind_type kind,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [WORD_W-1:0] word);
      list_reply_type reply;
      int unsigned idx;
      reply.status = ST_RANGE;
      reply.word   = '0;
      case (kind)
         KIND_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = word;
               shadow_count++;
               reply.status = ST_DONE;
            end
         end
         KIND_DELETE: begin
            if (pos < shadow_count && pos < CAPACITY) begin
               // close the gap, order kept
               for (idx = pos + 1; idx < shadow_count && idx < CAPACITY; idx++)
                  shadow_words[idx - 1] = shadow_words[idx];
               shadow_count--;
               reply.status = ST_DONE;
            end
         end
         KIND_GET: begin
            if (pos < shadow_count && pos < CAPACITY) begin
               reply.word   = shadow_words[pos];
               reply.status = ST_DONE;
            end
         end
         default: ;  // unused kind: out of range, no change
      endcase
      reply.fill = shadow_count[FILL_W-1:0];
      return reply;
   endfunction

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         expected_replies.delete();
         shadow_count   = 0;
         mismatch_count = 0;
      end else begin
         // response transfer: compare with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_word_out !== want.word) begin
                  $error("word_out: expected %h, got %h", want.word, rsp_word_out);
                  mismatch_count++;
               end
               if (rsp_fill_count !== want.fill) begin
                  $error("fill_count: expected %0d, got %0d", want.fill, rsp_fill_count);
                  mismatch_count++;
               end
            end
         end
         // request transfer: predict its reply
         if (req_valid && !req_stall)
            expected_replies.push_back(apply_request(req_kind, req_position, req_word_in));
      end
      pending_replies = expected_replies.size();
      predicted_fill  = shadow_count;
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import clsc_pkg::*;

   localparam int unsigned   LIST_CAP    = 64;
   localparam int            CYCLE_LIMIT = 1000000;
   localparam clsc_kind_type KIND_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind;
   logic [POS_W-1:0]    req_position;
   logic [WORD_W-1:0]   req_word_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic [WORD_W-1:0]   rsp_word_out;
   logic [FILL_W-1:0]   rsp_fill_count;

   int mismatch_count;
   int pending_replies;
   int predicted_fill;

   int snd_idle_pct;
   int rcv_idle_pct;
   bit hold_request;
   bit filling;
   int cycle_count = 0;

   compacting_list_store_core #(.CAPACITY(LIST_CAP)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_word_in    (req_word_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_word_out   (rsp_word_out),
      .rsp_fill_count (rsp_fill_count)
   );

   list_store_checker #(.CAPACITY(LIST_CAP)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_word_in     (req_word_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_word_out    (rsp_word_out),
      .rsp_fill_count  (rsp_fill_count),
      .mismatch_count  (mismatch_count),
      .pending_replies (pending_replies),
      .predicted_fill  (predicted_fill)
   );

   // Clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off counted here
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = 400;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (rcv_idle_pct != 0) && ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // One request transfer; entered and left at a falling edge
   task automatic send_request(input clsc_kind_type kind, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] word);
      while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_word_in  <= word;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Random request, drifting between filling and draining the list
   task automatic send_random();
      int            roll;
      int            cnt;
      clsc_kind_type kind;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] word;
      cnt = predicted_fill;
      if (cnt >= LIST_CAP && $urandom_range(99) < 30) filling = 1'b0;
      else if (cnt == 0) filling = 1'b1;
      else if ($urandom_range(99) < 2) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 3) kind = KIND_UNUSED;
      else if (filling) kind = (roll < 62) ? KIND_APPEND : (roll < 87) ? KIND_GET : KIND_DELETE;
      else kind = (roll < 20) ? KIND_APPEND : (roll < 70) ? KIND_DELETE : KIND_GET;
      // mostly valid indexes, some anywhere in the field
      if (cnt > 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(cnt - 1));
      else pos = POS_W'($urandom_range(63));
      roll = $urandom_range(99);
      if (roll < 4) word = '0;
      else if (roll < 8) word = '1;
      else word = {$urandom, $urandom};
      send_request(kind, pos, word);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies != 0) @(negedge clock);
   endtask

   // Stimulus and verdict
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = KIND_APPEND;
      req_position = '0;
      req_word_in  = '0;
      snd_idle_pct = 13;
      rcv_idle_pct = 50;
      hold_request = 1'b0;
      filling      = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, extremes, first/middle/last delete, bounds
      send_request(KIND_GET,    6'd0,  '0);
      send_request(KIND_DELETE, 6'd0,  '0);
      send_request(KIND_UNUSED, 6'd63, '1);
      send_request(KIND_APPEND, 6'd63, '0);
      send_request(KIND_APPEND, 6'd0,  '1);
      send_request(KIND_APPEND, 6'd21, 64'hA5A5_A5A5_A5A5_A5A5);
      send_request(KIND_APPEND, 6'd42, 64'h5A5A_5A5A_5A5A_5A5A);
      send_request(KIND_APPEND, 6'd0,  64'h8000_0000_0000_0001);
      send_request(KIND_GET,    6'd0,  '0);
      send_request(KIND_GET,    6'd4,  '1);
      send_request(KIND_GET,    6'd5,  '0);
      send_request(KIND_GET,    6'd63, '0);
      send_request(KIND_DELETE, 6'd63, '0);
      send_request(KIND_DELETE, 6'd4,  '0);
      send_request(KIND_DELETE, 6'd0,  '0);
      send_request(KIND_GET,    6'd0,  '0);
      send_request(KIND_GET,    6'd1,  '0);
      send_request(KIND_GET,    6'd2,  '0);
      send_request(KIND_DELETE, 6'd1,  '0);
      send_request(KIND_GET,    6'd1,  '0);
      send_request(KIND_GET,    6'd2,  '0);
      send_request(KIND_UNUSED, 6'd0,  '0);

      // sender pauses until every reply is back
      drain_replies();

      // phase 1: light sender gaps, heavy receiver stall, one long hold-off
      repeat (300) send_random();
      hold_request = 1'b1;
      repeat (300) send_random();

      // phase 2: roles swapped
      snd_idle_pct = 50;
      rcv_idle_pct = 13;
      repeat (600) send_random();

      // phase 3: full rate both sides
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      repeat (630) send_random();

      drain_replies();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/clsc_pkg.sv
hw/rtl/clsc_ctrl.sv
hw/rtl/clsc_dpath.sv
hw/rtl/compacting_list_store_core.sv
hw/rtl/clsc_checker.sv
tb/list_store_checker.sv
tb/tb_top.sv
